[sv/fine_tune_accelerated_clamp_assert.svh]
// assertion macros shared by the fine-tune clamp block
`ifndef FINE_TUNE_ACCELERATED_CLAMP_ASSERT_SVH
`define FINE_TUNE_ACCELERATED_CLAMP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define FTAC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequence holds in the same cycle as the antecedent
`define FTAC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define FTAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ftac_pkg.sv]
// shared types and constants for the fine-tune clamp block
package ftac_pkg;

    localparam int VFO_COUNT = 2;
    localparam int VFO_IDX_W = (VFO_COUNT > 1) ? $clog2(VFO_COUNT) : 1;

    localparam int SR_W       = 20;
    localparam int ZOOM_W     = 3;
    localparam int MODE_W     = 2;
    localparam int CUT_W      = 18;
    localparam int STEP_W     = 17;
    localparam int DELTA_W    = 8;
    localparam int MS_W       = 32;
    localparam int HZ_W       = 24;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [MS_W-1:0]   CANCEL_MS    = 32'd500;
    localparam logic [MS_W-1:0]   SHORT_MS     = 32'd100;
    localparam logic [CNT_W-1:0]  TRIGGER      = 3'd4;
    localparam logic [STEP_W-1:0] FAST_STEP_HZ = 17'd1000;

    localparam logic [SR_W-1:0]   SAMPLE_RATE_RST = 20'd192000;
    localparam logic [STEP_W-1:0] BASE_STEP_RST   = 17'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE = 3'd0,
        REG_ZOOM        = 3'd1,
        REG_DEMOD       = 3'd2,
        REG_LOW_CUT     = 3'd3,
        REG_HIGH_CUT    = 3'd4,
        REG_BASE_STEP   = 3'd5,
        REG_ACTIVE_VFO  = 3'd6
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LSB  = 2'd0,
        MODE_USB  = 2'd1,
        MODE_SYM  = 2'd2,
        MODE_NONE = 2'd3
    } demod_t;

    typedef struct packed {
        logic [SR_W-1:0]   sample_rate_hz;
        logic [ZOOM_W-1:0] zoom_level;
        demod_t            demod_mode;
        logic [CUT_W-1:0]  low_cut_hz;
        logic [CUT_W-1:0]  high_cut_hz;
        logic [STEP_W-1:0] base_step_hz;
        logic              active_vfo;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             fast;
    } tune_t;

endpackage

[sv/ftac_calc.sv]
// per-event datapath: fast tune decision, step, window and clamp
module ftac_calc
    import ftac_pkg::*;
(
    input  cfg_t                    cfg,
    input  logic signed [DELTA_W-1:0] knob_delta,
    input  logic [MS_W-1:0]         now_ms,
    input  logic [MS_W-1:0]         last_ms,
    input  tune_t                   tune_cur,
    input  logic signed [HZ_W-1:0]  offset_cur,
    output tune_t                   tune_new,
    output logic signed [HZ_W-1:0]  offset_new
);

    localparam int PROD_W = STEP_W + 1 + DELTA_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int WIN_W  = SR_W + 2;
    localparam int F_W    = SUM_W + 1;

    logic [MS_W-1:0]          gap;
    logic [CNT_W-1:0]         cnt_inc;
    logic [STEP_W-1:0]        step;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  f_sum;
    logic [SR_W-1:0]          shifted;
    logic [SR_W-1:0]          half;
    logic signed [WIN_W-1:0]  half_s;
    logic signed [WIN_W-1:0]  low_s;
    logic signed [WIN_W-1:0]  high_s;
    logic signed [WIN_W-1:0]  low_abs;
    logic signed [WIN_W-1:0]  high_abs;
    logic signed [WIN_W-1:0]  edge_max;
    logic signed [WIN_W-1:0]  lower;
    logic signed [WIN_W-1:0]  upper;
    logic signed [F_W-1:0]    f0;
    logic signed [F_W-1:0]    f1;
    logic signed [F_W-1:0]    f2;
    logic signed [F_W-1:0]    neg_upper;
    logic signed [F_W-1:0]    neg_lower;

    // fast tune decision comes before the step
    always_comb
    begin
        gap      = now_ms - last_ms;
        cnt_inc  = (gap <= SHORT_MS) ? tune_cur.cnt + 3'd1 : tune_cur.cnt;
        tune_new = tune_cur;
        if (tune_cur.fast)
        begin
            if (gap >= CANCEL_MS)
                tune_new.fast = 1'b0;
        end
        else
        begin
            tune_new.cnt = cnt_inc;
            if (cnt_inc >= TRIGGER)
            begin
                tune_new.cnt  = '0;
                tune_new.fast = 1'b1;
            end
        end
    end

    assign step  = tune_new.fast ? FAST_STEP_HZ : cfg.base_step_hz;
    assign prod  = PROD_W'($signed({1'b0, step})) * PROD_W'(knob_delta);
    assign f_sum = SUM_W'(offset_cur) + SUM_W'(prod);

    // tuning window, narrowed by the filter edges
    assign shifted  = cfg.sample_rate_hz >> cfg.zoom_level;
    assign half     = shifted >> 1;
    assign half_s   = WIN_W'($signed({1'b0, half}));
    assign low_s    = WIN_W'($signed(cfg.low_cut_hz));
    assign high_s   = WIN_W'($signed(cfg.high_cut_hz));
    assign low_abs  = (low_s < 0) ? -low_s : low_s;
    assign high_abs = (high_s < 0) ? -high_s : high_s;
    assign edge_max = (high_abs > low_abs) ? high_abs : low_abs;

    always_comb
    begin
        lower = -half_s;
        upper = half_s;
        unique case (cfg.demod_mode)
            MODE_LSB:  lower = -half_s - low_s;
            MODE_USB:  upper = half_s - high_s;
            MODE_SYM:
            begin
                lower = -half_s + edge_max;
                upper = half_s - edge_max;
            end
            MODE_NONE: ;
            default:   ;
        endcase
    end

    // clamp the negated offset into the window, upper check first
    assign neg_upper = -F_W'(upper);
    assign neg_lower = -F_W'(lower);
    assign f0 = F_W'(f_sum);
    assign f1 = (f0 < neg_upper) ? neg_upper : f0;
    assign f2 = (f1 > neg_lower) ? neg_lower : f1;
    assign offset_new = f2[HZ_W-1:0];

endmodule

[sv/fine_tune_accelerated_clamp.sv]
// top level of the fine-tune knob handler with fast tune and window clamp
//
// input channel: in_valid / in_stall with knob_delta and now_ms; a transaction
//   completes on a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with fine_tune_hz and fast_tune_on,
//   one result transaction per input transaction, in order
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, indexes past the register list are ignored
// path: input register, then the single-pass datapath into the output register
// throughput: one event per cycle while the output queue has room; the datapath
//   is one multiply, two shifts and a few compares between the input register
//   and the output register
// a two-entry output queue (output register plus skid) lets a new event
//   enter while a result waits; in_stall rises only when both entries are
//   full and the input register holds an event
// reset: both VFO offsets, the last timestamp, the short-gap count and the
//   fast flag clear; config registers load their defaults
// under out_stall the head result holds steady until taken
`include "fine_tune_accelerated_clamp_assert.svh"

module fine_tune_accelerated_clamp
    import ftac_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [DELTA_W-1:0] knob_delta,
    input  logic [MS_W-1:0]           now_ms,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [HZ_W-1:0]    fine_tune_hz,
    output logic                      fast_tune_on,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    cfg_t cfg_reg;

    // input register
    logic                      in_v_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [MS_W-1:0]           now_reg;

    // tuning state
    logic [MS_W-1:0]          last_ms_reg;
    tune_t                    tune_reg;
    logic signed [HZ_W-1:0]   offset_reg [VFO_COUNT];

    // output queue: head drives the ports, skid catches one more
    logic                     head_v_reg;
    logic                     head_v_next;
    logic signed [HZ_W-1:0]   head_hz_reg;
    logic signed [HZ_W-1:0]   head_hz_next;
    logic                     head_fast_reg;
    logic                     head_fast_next;
    logic                     skid_v_reg;
    logic                     skid_v_next;
    logic signed [HZ_W-1:0]   skid_hz_reg;
    logic signed [HZ_W-1:0]   skid_hz_next;
    logic                     skid_fast_reg;
    logic                     skid_fast_next;

    logic                     advance;
    logic                     can_load;
    logic                     pop;
    logic [VFO_IDX_W-1:0]     vfo_sel;
    tune_t                    tune_new;
    logic signed [HZ_W-1:0]   offset_new;

    assign cfg_ready = 1'b1;

    // config writes, each field truncated to its width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_rate_hz <= SAMPLE_RATE_RST;
            cfg_reg.zoom_level     <= '0;
            cfg_reg.demod_mode     <= MODE_LSB;
            cfg_reg.low_cut_hz     <= '0;
            cfg_reg.high_cut_hz    <= '0;
            cfg_reg.base_step_hz   <= BASE_STEP_RST;
            cfg_reg.active_vfo     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SAMPLE_RATE: cfg_reg.sample_rate_hz <= cfg_data[SR_W-1:0];
                REG_ZOOM:        cfg_reg.zoom_level     <= cfg_data[ZOOM_W-1:0];
                REG_DEMOD:       cfg_reg.demod_mode     <= demod_t'(cfg_data[MODE_W-1:0]);
                REG_LOW_CUT:     cfg_reg.low_cut_hz     <= cfg_data[CUT_W-1:0];
                REG_HIGH_CUT:    cfg_reg.high_cut_hz    <= cfg_data[CUT_W-1:0];
                REG_BASE_STEP:   cfg_reg.base_step_hz   <= cfg_data[STEP_W-1:0];
                REG_ACTIVE_VFO:  cfg_reg.active_vfo     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // the event in the input register moves on whenever the queue has room
    assign advance  = in_v_reg && !(head_v_reg && skid_v_reg);
    assign can_load = !in_v_reg || advance;
    assign in_stall = !can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (can_load)
            in_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (can_load && in_valid)
        begin
            delta_reg <= knob_delta;
            now_reg   <= now_ms;
        end
    end

    // an out-of-range vfo select falls back to the last vfo
    assign vfo_sel = (int'(cfg_reg.active_vfo) >= VFO_COUNT) ?
                     VFO_IDX_W'(VFO_COUNT - 1) : VFO_IDX_W'(cfg_reg.active_vfo);

    ftac_calc u_calc (
        .cfg        (cfg_reg),
        .knob_delta (delta_reg),
        .now_ms     (now_reg),
        .last_ms    (last_ms_reg),
        .tune_cur   (tune_reg),
        .offset_cur (offset_reg[vfo_sel]),
        .tune_new   (tune_new),
        .offset_new (offset_new)
    );

    // state commits in the cycle the result enters the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ms_reg <= '0;
            tune_reg    <= '0;
            for (int i = 0; i < VFO_COUNT; i++)
                offset_reg[i] <= '0;
        end
        else if (advance)
        begin
            last_ms_reg         <= now_reg;
            tune_reg            <= tune_new;
            offset_reg[vfo_sel] <= offset_new;
        end
    end

    // output queue: pop the head, slide the skid forward, push the new result
    assign pop = head_v_reg && !out_stall;

    always_comb
    begin
        head_v_next    = head_v_reg && !pop;
        head_hz_next   = head_hz_reg;
        head_fast_next = head_fast_reg;
        skid_v_next    = skid_v_reg;
        skid_hz_next   = skid_hz_reg;
        skid_fast_next = skid_fast_reg;
        if (!head_v_next && skid_v_next)
        begin
            head_v_next    = 1'b1;
            head_hz_next   = skid_hz_reg;
            head_fast_next = skid_fast_reg;
            skid_v_next    = 1'b0;
        end
        if (advance)
        begin
            if (!head_v_next)
            begin
                head_v_next    = 1'b1;
                head_hz_next   = offset_new;
                head_fast_next = tune_new.fast;
            end
            else
            begin
                skid_v_next    = 1'b1;
                skid_hz_next   = offset_new;
                skid_fast_next = tune_new.fast;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            head_v_reg <= head_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_hz_reg   <= head_hz_next;
        head_fast_reg <= head_fast_next;
        skid_hz_reg   <= skid_hz_next;
        skid_fast_reg <= skid_fast_next;
    end

    assign out_valid    = head_v_reg;
    assign fine_tune_hz = head_hz_reg;
    assign fast_tune_on = head_fast_reg;

    // checks on queue order and fast tune bookkeeping
    `FTAC_ASSERT_ALWAYS(a_skid_needs_head, !skid_v_reg || head_v_reg, "skid filled without head")
    `FTAC_ASSERT_ALWAYS(a_count_below_trigger, tune_reg.cnt < TRIGGER, "short gap count at trigger")
    `FTAC_ASSERT_IMPL(a_fast_on_by_event, $rose(tune_reg.fast), $past(advance), "fast tune without event")
    `FTAC_ASSERT_NEXT(a_push_shows_result, advance, head_v_reg, "pushed result not visible")
    `FTAC_ASSERT_IMPL(a_stall_only_full, in_stall, in_v_reg && head_v_reg && skid_v_reg, "stall with room")

endmodule

[verif/ftac_tune_checker.sv]
// checker for the fine-tune clamp block: predicts each result and compares it on the output
module ftac_tune_checker
    import ftac_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic signed [DELTA_W-1:0] knob_delta,
    input  logic [MS_W-1:0]           now_ms,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [HZ_W-1:0]    fine_tune_hz,
    input  logic                      fast_tune_on,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output int                        mismatch_count,
    output int                        tunes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [HZ_W-1:0] fine_hz;
        logic                   fast_on;
    } tune_result_t;

    // register copies
    logic [SR_W-1:0]          rate_hz;
    logic [ZOOM_W-1:0]        zoom;
    demod_t                   mode_sel;
    logic signed [CUT_W-1:0]  low_cut;
    logic signed [CUT_W-1:0]  high_cut;
    logic [STEP_W-1:0]        base_step;
    logic                     vfo_sel;

    // tuning state
    logic signed [HZ_W-1:0]   offset_hz [VFO_COUNT];
    logic [MS_W-1:0]          last_ms;
    logic [CNT_W-1:0]         gap_count;
    logic                     fast;

    tune_result_t             expected_tunes [$];
    tune_result_t             want;

    // advances the tuning state by one knob event and returns the new offset and fast flag
    function automatic tune_result_t next_tune(input logic signed [DELTA_W-1:0] delta,
                                               input logic [MS_W-1:0] stamp);
        logic [MS_W-1:0] gap;
        int              slot;
        longint          step;
        longint          f;
        longint          half;
        longint          lower;
        longint          upper;
        longint          lo_abs;
        longint          hi_abs;
        longint          edge_hz;
        tune_result_t    r;

        gap     = stamp - last_ms;
        last_ms = stamp;
        if (fast) begin
            if (gap >= CANCEL_MS)
                fast = 1'b0;
        end
        else begin
            if (gap <= SHORT_MS)
                gap_count = gap_count + 1'b1;
            if (gap_count >= TRIGGER) begin
                gap_count = '0;
                fast      = 1'b1;
            end
        end

        slot = (int'(vfo_sel) >= VFO_COUNT) ? VFO_COUNT - 1 : int'(vfo_sel);
        step = fast ? longint'(FAST_STEP_HZ) : longint'(base_step);
        f    = longint'(offset_hz[slot]) + step * longint'(delta);

        half  = longint'((rate_hz >> zoom) >> 1);
        lower = -half;
        upper = half;
        lo_abs = (low_cut < 0) ? -longint'(low_cut) : longint'(low_cut);
        hi_abs = (high_cut < 0) ? -longint'(high_cut) : longint'(high_cut);
        case (mode_sel)
            MODE_LSB: lower = lower - longint'(low_cut);
            MODE_USB: upper = upper - longint'(high_cut);
            MODE_SYM:
            begin
                edge_hz = (hi_abs > lo_abs) ? hi_abs : lo_abs;
                lower   = lower + edge_hz;
                upper   = upper - edge_hz;
            end
            default: ;
        endcase

        // upper bound first, so the lower bound wins on an inverted window
        if (-f > upper)
            f = -upper;
        if (-f < lower)
            f = -lower;

        offset_hz[slot] = f[HZ_W-1:0];
        r.fine_hz = f[HZ_W-1:0];
        r.fast_on = fast;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rate_hz   = SAMPLE_RATE_RST;
            zoom      = '0;
            mode_sel  = MODE_LSB;
            low_cut   = '0;
            high_cut  = '0;
            base_step = BASE_STEP_RST;
            vfo_sel   = 1'b0;
            for (int i = 0; i < VFO_COUNT; i++)
                offset_hz[i] = '0;
            last_ms   = '0;
            gap_count = '0;
            fast      = 1'b0;
            expected_tunes.delete();
            mismatch_count = 0;
            tunes_pending  = 0;
        end
        else begin
            // results first: they belong to events accepted on earlier edges
            if (out_valid && !out_stall) begin
                if (expected_tunes.size() == 0) begin
                    $error("unexpected result: fine_tune_hz %0d fast_tune_on %0b",
                           fine_tune_hz, fast_tune_on);
                    mismatch_count++;
                end
                else begin
                    want = expected_tunes.pop_front();
                    if (fine_tune_hz !== want.fine_hz) begin
                        $error("fine_tune_hz expected %0d actual %0d",
                               want.fine_hz, fine_tune_hz);
                        mismatch_count++;
                    end
                    if (fast_tune_on !== want.fast_on) begin
                        $error("fast_tune_on expected %0b actual %0b",
                               want.fast_on, fast_tune_on);
                        mismatch_count++;
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SAMPLE_RATE: rate_hz   = cfg_data[SR_W-1:0];
                    REG_ZOOM:        zoom      = cfg_data[ZOOM_W-1:0];
                    REG_DEMOD:       mode_sel  = demod_t'(cfg_data[MODE_W-1:0]);
                    REG_LOW_CUT:     low_cut   = cfg_data[CUT_W-1:0];
                    REG_HIGH_CUT:    high_cut  = cfg_data[CUT_W-1:0];
                    REG_BASE_STEP:   base_step = cfg_data[STEP_W-1:0];
                    REG_ACTIVE_VFO:  vfo_sel   = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                expected_tunes.push_back(next_tune(knob_delta, now_ms));

            tunes_pending = expected_tunes.size();
        end
    end

endmodule

[verif/tb.sv]
// top of the fine-tune clamp testbench: clock, reset, stimulus and verdict
module tb
    import ftac_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // idle chance per cycle, in percent, for both sides
    localparam int IDLE_PCT      = 29;
    // generous bound on the whole run
    localparam int CYCLE_LIMIT   = 400000;
    // cycles to let pass once nothing is expected any more
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_EVENTS  = 108;
    // the phase run without idling, with the long output hold-off
    localparam int CALM_PHASE    = 2;
    localparam int BURST_CYCLES  = 60;
    // index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 3'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [DELTA_W-1:0] knob_delta;
    logic [MS_W-1:0]           now_ms;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [HZ_W-1:0]    fine_tune_hz;
    logic                      fast_tune_on;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    int                        mismatch_count;
    int                        tunes_pending;

    // set by the stimulus: no idling on either side while high
    logic                      calm = 1'b0;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int                        bursts_asked = 0;

    fine_tune_accelerated_clamp dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .knob_delta   (knob_delta),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fine_tune_hz (fine_tune_hz),
        .fast_tune_on (fast_tune_on),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // watches all three channels and keeps the expected results
    ftac_tune_checker tune_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .knob_delta     (knob_delta),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fine_tune_hz   (fine_tune_hz),
        .fast_tune_on   (fast_tune_on),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .tunes_pending  (tunes_pending)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: a run that hangs ends here
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // result side: random stalls, none while calm, and one long hold-off on request
    initial
    begin : receiver
        int bursts_done;
        bursts_done = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (bursts_done != bursts_asked)
            begin
                // hold off long enough for the output queue and the input register to fill
                bursts_done = bursts_asked;
                out_stall <= 1'b1;
                repeat (BURST_CYCLES) @(posedge clk);
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // one register write transaction; cfg_valid stays high for the next one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
    endtask

    // ends a run of register writes
    task automatic cfg_close();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // offers one knob event after random idle cycles and waits for its transaction
    task automatic send_event(input logic signed [DELTA_W-1:0] delta,
                              input logic [MS_W-1:0] stamp);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        knob_delta <= delta;
        now_ms     <= stamp;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic finish_events();
        in_valid <= 1'b0;
    endtask

    // waits until every expected result has come out, then lets the output settle
    task automatic wait_drained();
        @(negedge clk);
        while (tunes_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // gap to the next event: mostly short bursts that build up fast tune
    function automatic logic [MS_W-1:0] pick_gap();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $urandom_range(0, 100);
        if (pick == 5)
        begin
            // right at the short and cancel thresholds
            case ($urandom_range(0, 3))
                0:       return SHORT_MS;
                1:       return SHORT_MS + 1;
                2:       return CANCEL_MS - 1;
                default: return CANCEL_MS;
            endcase
        end
        if (pick == 6)
            return $urandom_range(101, 499);
        if (pick == 7)
            return $urandom_range(500, 5000);
        if (pick == 8)
            return $urandom;
        return '0;
    endfunction

    // knob steps: full range, small turns and the extremes
    function automatic logic signed [DELTA_W-1:0] pick_delta();
        int                        pick;
        logic signed [DELTA_W-1:0] d;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            d = DELTA_W'($urandom_range(0, 255));
        else if (pick < 9)
            d = DELTA_W'(int'($urandom_range(0, 6)) - 3);
        else
            d = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
        return d;
    endfunction

    // random register set, with the range ends showing up now and then
    task automatic random_config();
        int rate;
        int lo;
        int hi;
        int step;
        case ($urandom_range(0, 3))
            0:       rate = $urandom_range(0, 1000000);
            1:       rate = 1000000;
            2:       rate = 192000;
            default: rate = $urandom_range(0, 2000);
        endcase
        if ($urandom_range(0, 1))
        begin
            // usual filter: low edge below, high edge above the carrier
            lo = -int'($urandom_range(0, 5000));
            hi = $urandom_range(0, 5000);
        end
        else
        begin
            lo = int'($urandom_range(0, 200000)) - 100000;
            hi = int'($urandom_range(0, 200000)) - 100000;
        end
        case ($urandom_range(0, 9))
            0:       step = 100000;
            1, 2:    step = $urandom_range(1, 100000);
            default: step = $urandom_range(1, 2000);
        endcase
        cfg_write(REG_SAMPLE_RATE, rate);
        cfg_write(REG_ZOOM, $urandom_range(0, 7));
        cfg_write(REG_DEMOD, $urandom_range(0, 3));
        cfg_write(REG_LOW_CUT, lo);
        cfg_write(REG_HIGH_CUT, hi);
        cfg_write(REG_BASE_STEP, step);
        cfg_write(REG_ACTIVE_VFO, $urandom_range(0, 1));
        cfg_close();
    endtask

    initial
    begin : stimulus
        logic [MS_W-1:0] stamp;
        int              p;
        int              n;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        knob_delta = '0;
        now_ms     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // typical sideband setup, plus a write to an index past the list
        cfg_write(REG_SAMPLE_RATE, 192000);
        cfg_write(REG_ZOOM, 0);
        cfg_write(REG_DEMOD, MODE_LSB);
        cfg_write(REG_LOW_CUT, -3000);
        cfg_write(REG_HIGH_CUT, 3000);
        cfg_write(REG_BASE_STEP, 10);
        cfg_write(REG_ACTIVE_VFO, 0);
        cfg_write(UNUSED_REG, 20'hFFFFF);
        cfg_close();

        // short gaps build the count: 0, 50 and exactly 100 ms count, 101 ms does not
        send_event(8'sd127, 32'd0);
        send_event(-8'sd128, 32'd50);
        send_event(8'sd1, 32'd150);
        send_event(8'sd1, 32'd251);
        // fourth short gap turns fast tune on before the step is applied
        send_event(8'sd5, 32'd300);
        // 499 ms keeps fast tune, the offset runs into the window edge
        send_event(8'sd127, 32'd799);
        send_event(8'sd127, 32'd820);
        // exactly 500 ms cancels fast tune
        send_event(-8'sd128, 32'd1320);
        send_event(8'sd0, 32'hFFFF_FFFF);
        // timestamp wraps past zero, gap is still short
        send_event(-8'sd1, 32'h0000_0005);
        send_event(-8'sd128, 32'd10);
        send_event(-8'sd128, 32'd20);
        send_event(-8'sd128, 32'd30);
        // pinned on the other edge of the window
        send_event(-8'sd128, 32'd40);
        send_event(8'sd0, 32'h8000_0000);
        finish_events();
        wait_drained();

        // largest rate and step at deepest zoom: upper edge falls below lower edge
        cfg_write(REG_SAMPLE_RATE, 1000000);
        cfg_write(REG_ZOOM, 7);
        cfg_write(REG_DEMOD, MODE_USB);
        cfg_write(REG_LOW_CUT, -100000);
        cfg_write(REG_HIGH_CUT, 100000);
        cfg_write(REG_BASE_STEP, 100000);
        cfg_write(REG_ACTIVE_VFO, 1);
        cfg_close();
        send_event(8'sd127, 32'h8000_1000);
        send_event(-8'sd128, 32'h8000_2000);
        send_event(8'sd0, 32'h8000_3000);
        finish_events();
        wait_drained();

        // zero step and zero rate, symmetric edges wider than the window
        cfg_write(REG_SAMPLE_RATE, 0);
        cfg_write(REG_ZOOM, 0);
        cfg_write(REG_DEMOD, MODE_SYM);
        cfg_write(REG_LOW_CUT, 100000);
        cfg_write(REG_HIGH_CUT, -100000);
        cfg_write(REG_BASE_STEP, 0);
        cfg_write(REG_ACTIVE_VFO, 0);
        cfg_close();
        send_event(8'sd127, 32'h8000_4000);
        send_event(-8'sd128, 32'h8000_5000);
        send_event(8'sd3, 32'h8000_6000);
        finish_events();
        wait_drained();

        stamp = 32'h8000_6000;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            random_config();
            // one phase with no idling at all and a long output hold-off
            calm = (p == CALM_PHASE);
            if (calm)
                bursts_asked++;
            for (n = 0; n < PHASE_EVENTS; n++)
            begin
                stamp = stamp + pick_gap();
                send_event(pick_delta(), stamp);
            end
            finish_events();
            calm = 1'b0;
            wait_drained();
        end

        if (mismatch_count == 0 && tunes_pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

[fine_tune_accelerated_clamp.f]
+incdir+sv
sv/ftac_pkg.sv
sv/ftac_calc.sv
sv/fine_tune_accelerated_clamp.sv
verif/ftac_tune_checker.sv
verif/tb.sv
